// File: sv/dlta_pkg.sv
// Shared types and constants of the display list triangle assembler.
// Used by the front end, the job queue, the back end and the top level.
package dlta_pkg;

   // Default bound on descriptor slots in use, and the hardware slot count.
   localparam int MAX_ATTRS   = 8;
   localparam int SLOT_COUNT  = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [2:0] CSR_ATTR_COUNT     = 3'd0;
   localparam logic [2:0] CSR_ATTR_KINDS     = 3'd1;
   localparam logic [2:0] CSR_DIRECT_LENGTHS = 3'd2;
   localparam logic [2:0] CSR_STRIP_OPCODE   = 3'd3;
   localparam logic [2:0] CSR_FAN_OPCODE     = 3'd4;

   localparam logic [7:0] STRIP_OPCODE_RST = 8'd152;
   localparam logic [7:0] FAN_OPCODE_RST   = 8'd160;

   // Attribute kinds of a descriptor slot.
   localparam logic [1:0] ATTR_NONE    = 2'd0;
   localparam logic [1:0] ATTR_DIRECT  = 2'd1;
   localparam logic [1:0] ATTR_INDEX8  = 2'd2;
   localparam logic [1:0] ATTR_INDEX16 = 2'd3;

   typedef enum logic [1:0] {
      KIND_INDEX  = 2'd0,
      KIND_DIRECT = 2'd1,
      KIND_TRI    = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_CMD    = 2'd0,
      PH_CNT_HI = 2'd1,
      PH_CNT_LO = 2'd2,
      PH_REC    = 2'd3
   } phase_type;

   // All results caused by one request.
   typedef struct packed {
      logic        has_attr;
      logic        attr_direct;
      logic [2:0]  slot;
      logic [15:0] value;
      logic [31:0] vnum;
      logic        has_tri;
      logic [31:0] corner_a;
      logic [31:0] corner_b;
      logic [31:0] corner_c;
      logic        has_done;
   } job_type;

   // Queue status toward the producer and the consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: sv/dlta_front.sv
// Front end: configuration registers and the byte-serial display list parser.
// Depends on dlta_pkg; emits one job per request that causes any result.
module dlta_front import dlta_pkg::*; #(
   parameter int MAX_ATTRS = dlta_pkg::MAX_ATTRS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        final_byte,
   output logic        job_push,
   output job_type     job
);

   localparam int SLOT_CAP = (MAX_ATTRS < SLOT_COUNT) ? MAX_ATTRS : SLOT_COUNT;

   logic [3:0]  attr_count_ff;
   logic [15:0] attr_kinds_ff;
   logic [47:0] direct_lengths_ff;
   logic [7:0]  strip_opcode_ff;
   logic [7:0]  fan_opcode_ff;

   phase_type   phase_ff, phase_in;
   logic        fan_ff, fan_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] vip_ff, vip_in;
   logic [2:0]  slot_ff, slot_in;
   logic [5:0]  bytes_ff, bytes_in;
   logic [7:0]  hold_ff, hold_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] vctr_ff, vctr_in;
   logic        stopped_ff, stopped_in;

   logic [3:0]            limit;
   logic [SLOT_COUNT-1:0] carry;
   logic [3:0]            nc_zero;
   logic [3:0]            nc_next;
   logic [1:0]            cur_kind;
   logic [5:0]            cur_len;
   logic [5:0]            bytes_inc;
   logic [15:0]           new_left;

   // Returns {found, slot} of the first byte-carrying slot at or after from.
   function automatic logic [3:0] next_carrier(input logic [SLOT_COUNT-1:0] cv,
                                               input logic [3:0] from);
      logic       found;
      logic [2:0] hit;
      found = 1'b0;
      hit   = 3'd0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (!found && (4'(s) >= from) && cv[s]) begin
            found = 1'b1;
            hit   = 3'(s);
         end
      end
      return {found, hit};
   endfunction

   always_comb begin
      limit = (attr_count_ff > 4'(SLOT_CAP)) ? 4'(SLOT_CAP) : attr_count_ff;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         logic [1:0] k;
         k = (4'(s) < limit) ? attr_kinds_ff[2*s +: 2] : ATTR_NONE;
         carry[s] = (k == ATTR_INDEX8) || (k == ATTR_INDEX16) ||
                    ((k == ATTR_DIRECT) && (direct_lengths_ff[6*s +: 6] != 6'd0));
      end
   end

   assign nc_zero   = next_carrier(carry, 4'd0);
   assign nc_next   = next_carrier(carry, {1'b0, slot_ff} + 4'd1);
   assign cur_kind  = ({1'b0, slot_ff} < limit) ? attr_kinds_ff[{slot_ff, 1'b0} +: 2]
                                                 : ATTR_NONE;
   assign cur_len   = direct_lengths_ff[6*slot_ff +: 6];
   assign bytes_inc = bytes_ff + 6'd1;
   assign new_left  = left_ff - 16'd1;

   always_comb begin
      logic        done;
      logic [31:0] ta, tb, tc;
      logic        tri_ok;
      phase_in   = phase_ff;
      fan_in     = fan_ff;
      left_in    = left_ff;
      vip_in     = vip_ff;
      slot_in    = slot_ff;
      bytes_in   = bytes_ff;
      hold_in    = hold_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      vctr_in    = vctr_ff;
      stopped_in = stopped_ff;
      job        = '0;
      done       = 1'b1;
      ta         = '0;
      tb         = '0;
      tc         = '0;
      tri_ok     = 1'b0;

      if (!stopped_ff) begin
         case (phase_ff)
            PH_CMD: begin
               if (data_byte == strip_opcode_ff) begin
                  fan_in   = 1'b0;
                  phase_in = PH_CNT_HI;
               end else if (data_byte == fan_opcode_ff) begin
                  fan_in   = 1'b1;
                  phase_in = PH_CNT_HI;
               end else begin
                  stopped_in = 1'b1;
               end
            end
            PH_CNT_HI: begin
               hold_in  = data_byte;
               phase_in = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               left_in  = {hold_ff, data_byte};
               vip_in   = 16'd0;
               hold_in  = 8'd0;
               bytes_in = 6'd0;
               if ({hold_ff, data_byte} == 16'd0) begin
                  phase_in = PH_CMD;
               end else if (!nc_zero[3]) begin
                  left_in  = 16'd0;
                  slot_in  = 3'd0;
                  phase_in = PH_CMD;
               end else begin
                  slot_in  = nc_zero[2:0];
                  phase_in = PH_REC;
               end
            end
            default: begin
               case (cur_kind)
                  ATTR_DIRECT: begin
                     job.has_attr    = 1'b1;
                     job.attr_direct = 1'b1;
                     job.value       = {8'd0, data_byte};
                     bytes_in        = bytes_inc;
                     if ((bytes_inc != 6'd0) && (bytes_inc < cur_len)) begin
                        done = 1'b0;
                     end else begin
                        bytes_in = 6'd0;
                     end
                  end
                  ATTR_INDEX8: begin
                     job.has_attr = 1'b1;
                     job.value    = {8'd0, data_byte};
                     bytes_in     = 6'd0;
                  end
                  ATTR_INDEX16: begin
                     if (bytes_ff == 6'd0) begin
                        hold_in  = data_byte;
                        bytes_in = 6'd1;
                        done     = 1'b0;
                     end else begin
                        job.has_attr = 1'b1;
                        job.value    = {hold_ff, data_byte};
                        bytes_in     = 6'd0;
                        hold_in      = 8'd0;
                     end
                  end
                  default: begin
                     bytes_in = 6'd0;
                  end
               endcase
               job.slot = slot_ff;
               job.vnum = vctr_ff;
               if (!job.has_attr) begin
                  job.slot = 3'd0;
                  job.vnum = 32'd0;
               end

               if (done) begin
                  if (nc_next[3]) begin
                     slot_in = nc_next[2:0];
                  end else begin
                     // The record is complete: number the vertex and form triangles.
                     if (fan_ff) begin
                        if (vip_ff == 16'd0) begin
                           first_in = vctr_ff;
                        end else if (vip_ff >= 16'd2) begin
                           tri_ok = 1'b1;
                           ta     = first_ff;
                           tb     = prev_ff;
                           tc     = vctr_ff;
                        end
                     end else if (vip_ff >= 16'd2) begin
                        tri_ok = 1'b1;
                        tc     = vctr_ff;
                        if (!vip_ff[0]) begin
                           ta = vctr_ff - 32'd2;
                           tb = vctr_ff - 32'd1;
                        end else begin
                           ta = vctr_ff - 32'd1;
                           tb = vctr_ff - 32'd2;
                        end
                     end
                     if (tri_ok && (ta != tb) && (tb != tc) && (ta != tc)) begin
                        job.has_tri  = 1'b1;
                        job.corner_a = ta;
                        job.corner_b = tb;
                        job.corner_c = tc;
                     end
                     prev_in = vctr_ff;
                     vctr_in = vctr_ff + 32'd1;
                     vip_in  = vip_ff + 16'd1;
                     left_in = new_left;
                     if (new_left == 16'd0) begin
                        slot_in  = 3'd0;
                        bytes_in = 6'd0;
                        phase_in = PH_CMD;
                     end else begin
                        bytes_in = 6'd0;
                        hold_in  = 8'd0;
                        if (!nc_zero[3]) begin
                           left_in  = 16'd0;
                           slot_in  = 3'd0;
                           phase_in = PH_CMD;
                        end else begin
                           slot_in  = nc_zero[2:0];
                           phase_in = PH_REC;
                        end
                     end
                  end
               end
            end
         endcase
      end

      if (final_byte) begin
         job.has_done = 1'b1;
         phase_in     = PH_CMD;
         fan_in       = 1'b0;
         left_in      = 16'd0;
         vip_in       = 16'd0;
         slot_in      = 3'd0;
         bytes_in     = 6'd0;
         hold_in      = 8'd0;
         stopped_in   = 1'b0;
      end
   end

   assign job_push = take && (job.has_attr || job.has_tri || job.has_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_count_ff     <= 4'd0;
         attr_kinds_ff     <= 16'd0;
         direct_lengths_ff <= 48'd0;
         strip_opcode_ff   <= STRIP_OPCODE_RST;
         fan_opcode_ff     <= FAN_OPCODE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTR_COUNT:     attr_count_ff     <= csr_data[3:0];
            CSR_ATTR_KINDS:     attr_kinds_ff     <= csr_data[15:0];
            CSR_DIRECT_LENGTHS: direct_lengths_ff <= csr_data;
            CSR_STRIP_OPCODE:   strip_opcode_ff   <= csr_data[7:0];
            CSR_FAN_OPCODE:     fan_opcode_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CMD;
         fan_ff     <= 1'b0;
         left_ff    <= 16'd0;
         vip_ff     <= 16'd0;
         slot_ff    <= 3'd0;
         bytes_ff   <= 6'd0;
         hold_ff    <= 8'd0;
         first_ff   <= 32'd0;
         prev_ff    <= 32'd0;
         vctr_ff    <= 32'd0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         fan_ff     <= fan_in;
         left_ff    <= left_in;
         vip_ff     <= vip_in;
         slot_ff    <= slot_in;
         bytes_ff   <= bytes_in;
         hold_ff    <= hold_in;
         first_ff   <= first_in;
         prev_ff    <= prev_in;
         vctr_ff    <= vctr_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: sv/dlta_queue.sv
// Short job queue between the parser and the result sequencer.
// Depends on dlta_pkg for the job type and the queue depth.
module dlta_queue import dlta_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head_job,
   output qstat_type stat
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   assign stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head_job   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: sv/dlta_back.sv
// Back end: steps through the results of the job at the queue head, one per cycle while rsp_ready is high.
// Depends on dlta_pkg for the job and result kind types.
module dlta_back import dlta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  job_type     head_job,
   input  qstat_type   stat,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_attr_slot,
   output logic [15:0] rsp_attr_value,
   output logic [31:0] rsp_vertex_number,
   output logic [31:0] rsp_corner_a,
   output logic [31:0] rsp_corner_b,
   output logic [31:0] rsp_corner_c,
   output logic        rsp_end_of_run
);

   // Bit 0 attribute, bit 1 triangle, bit 2 list done.
   logic [2:0] sent_ff, sent_in;
   logic [2:0] left;
   logic [2:0] pick;
   kind_type   kind;
   logic       fire;

   assign left = {head_job.has_done, head_job.has_tri, head_job.has_attr} & ~sent_ff;
   assign pick = left[0] ? 3'b001 : (left[1] ? 3'b010 : 3'b100);
   assign fire = rsp_valid && rsp_ready;

   assign rsp_valid      = !stat.empty;
   assign rsp_end_of_run = ((left & ~pick) == 3'b000);
   assign pop            = fire && rsp_end_of_run;

   always_comb begin
      rsp_attr_slot     = 3'd0;
      rsp_attr_value    = 16'd0;
      rsp_vertex_number = 32'd0;
      rsp_corner_a      = 32'd0;
      rsp_corner_b      = 32'd0;
      rsp_corner_c      = 32'd0;
      case (pick)
         3'b001: begin
            kind              = head_job.attr_direct ? KIND_DIRECT : KIND_INDEX;
            rsp_attr_slot     = head_job.slot;
            rsp_attr_value    = head_job.value;
            rsp_vertex_number = head_job.vnum;
         end
         3'b010: begin
            kind         = KIND_TRI;
            rsp_corner_a = head_job.corner_a;
            rsp_corner_b = head_job.corner_b;
            rsp_corner_c = head_job.corner_c;
         end
         default: begin
            kind = KIND_DONE;
         end
      endcase
   end

   assign rsp_kind = kind;

   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = 3'b000;
      end else if (fire) begin
         sent_in = sent_ff | pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= 3'b000;
      end else begin
         sent_ff <= sent_in;
      end
   end

endmodule

// File: sv/display_list_triangle_assembler.sv
// Display list triangle assembler: parses one display list byte per cycle while the queue has room.
// With the job queue empty, a request's first result is offered in the cycle after it is taken.
// A request with several results holds the back end while it offers them in turn, and the
// four-entry job queue lets the parser run ahead until full.
// Reset is synchronous and active high; it clears all control and parse state with no
// clearing pass, and queue storage is never offered as a valid result before it is written.
module display_list_triangle_assembler import dlta_pkg::*; #(
   parameter int MAX_ATTRS = dlta_pkg::MAX_ATTRS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_attr_slot,
   output logic [15:0] rsp_attr_value,
   output logic [31:0] rsp_vertex_number,
   output logic [31:0] rsp_corner_a,
   output logic [31:0] rsp_corner_b,
   output logic [31:0] rsp_corner_c,
   output logic        rsp_end_of_run
);

   // The front end parses each request in the cycle it is accepted and
   // gathers every result that the byte causes into one job. Requests that
   // cause no result update the parser state only and never reach the queue.
   job_type   front_job;
   job_type   head_job;
   logic      job_push;
   logic      job_pop;
   logic      take;
   qstat_type stat;

   // A request is taken whenever the queue has room, so the parser keeps
   // running while the back end still waits on a stalled result.
   assign req_ready = !stat.full;
   assign take      = req_valid && req_ready;

   dlta_front #(
      .MAX_ATTRS (MAX_ATTRS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .take       (take),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .job_push   (job_push),
      .job        (front_job)
   );

   // The queue entries are registers, so the result channel is driven
   // from storage and never combinationally from the request side.
   dlta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (job_pop),
      .head_job (head_job),
      .stat     (stat)
   );

   // The back end offers the attribute, then the triangle, then the list
   // done result of the head job, and marks the last one as end of run.
   dlta_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .stat              (stat),
      .pop               (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_attr_slot     (rsp_attr_slot),
      .rsp_attr_value    (rsp_attr_value),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_corner_a      (rsp_corner_a),
      .rsp_corner_b      (rsp_corner_b),
      .rsp_corner_c      (rsp_corner_c),
      .rsp_end_of_run    (rsp_end_of_run)
   );

endmodule
